>>> design/bzc_pkg.sv
package bzc_pkg;

   localparam int MAX_WIDTH = 256;
   localparam int MAX_HEIGHT = 256;
   localparam int OUT_LIMIT = 4096;

   localparam int PIXEL_BITS = 16;
   localparam int COORD_BITS = 12;
   localparam int SIZE_BITS = 13;
   localparam int STEP_BITS = 17;
   localparam int FRAC_BITS = 16;
   localparam int PROD_BITS = SIZE_BITS + STEP_BITS;
   localparam int INT_BITS = PROD_BITS - FRAC_BITS;
   localparam int MIX_BITS = PIXEL_BITS + FRAC_BITS;

   localparam int WIDTH_BITS = $clog2(MAX_WIDTH + 1);
   localparam int HEIGHT_BITS = $clog2(MAX_HEIGHT + 1);
   localparam int COL_BITS = $clog2(MAX_WIDTH);
   localparam int ROW_BITS = $clog2(MAX_HEIGHT);
   localparam int STORE_DEPTH = MAX_WIDTH * MAX_HEIGHT;
   localparam int ADDR_BITS = $clog2(STORE_DEPTH);
   localparam int TOTAL_BITS = $clog2(STORE_DEPTH + 1);

   localparam int CSR_ADDR_BITS = 5;
   localparam int CSR_DATA_BITS = 32;

   localparam int QUEUE_DEPTH = 2;
   localparam int QUEUE_PTR_BITS = $clog2(QUEUE_DEPTH);
   localparam int QUEUE_CNT_BITS = $clog2(QUEUE_DEPTH + 1);

   typedef enum logic {
      OP_LOAD = 1'b0,
      OP_EMIT = 1'b1
   } opcode_type;

   typedef enum logic [2:0] {
      REG_SOURCE_WIDTH  = 3'd0,
      REG_SOURCE_HEIGHT = 3'd1,
      REG_STEP          = 3'd2,
      REG_SCALED_WIDTH  = 3'd3,
      REG_SCALED_HEIGHT = 3'd4,
      REG_EMIT_FULL     = 3'd5
   } reg_index_type;

   typedef struct packed {
      logic [WIDTH_BITS-1:0]  width;
      logic [HEIGHT_BITS-1:0] height;
      logic [TOTAL_BITS-1:0]  total;
      logic [STEP_BITS-1:0]   step;
      logic [SIZE_BITS-1:0]   out_width;
      logic [SIZE_BITS-1:0]   out_height;
      logic [COORD_BITS-1:0]  off_x;
      logic [COORD_BITS-1:0]  off_y;
   } cfg_type;

   typedef struct packed {
      opcode_type            opcode;
      logic [PIXEL_BITS-1:0] pixel;
   } item_type;

   typedef struct packed {
      logic [PIXEL_BITS-1:0] pixel;
      logic [COORD_BITS-1:0] x;
      logic [COORD_BITS-1:0] y;
      logic                  last;
   } result_type;

   function automatic logic [QUEUE_PTR_BITS-1:0] queue_next(
      input logic [QUEUE_PTR_BITS-1:0] p
   );
      logic [QUEUE_PTR_BITS-1:0] r;
      if (p == QUEUE_PTR_BITS'(QUEUE_DEPTH - 1)) begin
         r = '0;
      end else begin
         r = p + 1'b1;
      end
      return r;
   endfunction

endpackage

>>> design/bzc_ram.sv
module bzc_ram #(
   parameter int WIDTH = 16,
   parameter int DEPTH = 256
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic                     rd_en,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

>>> design/bzc_csr.sv
module bzc_csr (
   input  logic                               clock,
   input  logic                               reset,
   input  logic                               psel,
   input  logic                               penable,
   input  logic                               pwrite,
   input  logic [bzc_pkg::CSR_ADDR_BITS-1:0]  paddr,
   input  logic [bzc_pkg::CSR_DATA_BITS-1:0]  pwdata,
   output logic [bzc_pkg::CSR_DATA_BITS-1:0]  prdata,
   output bzc_pkg::cfg_type                   cfg
);

   logic [8:0]                       src_w_ff;
   logic [8:0]                       src_h_ff;
   logic [bzc_pkg::STEP_BITS-1:0]    step_ff;
   logic [bzc_pkg::SIZE_BITS-1:0]    scl_w_ff;
   logic [bzc_pkg::SIZE_BITS-1:0]    scl_h_ff;
   logic                             full_ff;
   bzc_pkg::cfg_type                 cfg_ff;
   bzc_pkg::cfg_type                 cfg_in;
   bzc_pkg::reg_index_type           index;
   logic                             wr_en;
   logic [bzc_pkg::SIZE_BITS-1:0]    w_size;
   logic [bzc_pkg::SIZE_BITS-1:0]    h_size;
   logic [bzc_pkg::SIZE_BITS-1:0]    sw_size;
   logic [bzc_pkg::SIZE_BITS-1:0]    sh_size;
   logic [bzc_pkg::SIZE_BITS-1:0]    diff_w;
   logic [bzc_pkg::SIZE_BITS-1:0]    diff_h;
   logic [bzc_pkg::WIDTH_BITS+bzc_pkg::HEIGHT_BITS-1:0] area;

   function automatic logic [bzc_pkg::SIZE_BITS-1:0] clamp_size(
      input logic [bzc_pkg::SIZE_BITS-1:0] v,
      input logic [bzc_pkg::SIZE_BITS-1:0] hi
   );
      logic [bzc_pkg::SIZE_BITS-1:0] r;
      if (v == '0) begin
         r = bzc_pkg::SIZE_BITS'(1);
      end else if (v > hi) begin
         r = hi;
      end else begin
         r = v;
      end
      return r;
   endfunction

   assign index = bzc_pkg::reg_index_type'(paddr[4:2]);
   assign wr_en = psel & penable & pwrite;

   always_ff @(posedge clock) begin
      if (reset) begin
         src_w_ff <= 9'd256;
         src_h_ff <= 9'd256;
         step_ff  <= 17'd65536;
         scl_w_ff <= 13'd256;
         scl_h_ff <= 13'd256;
         full_ff  <= 1'b0;
      end else if (wr_en) begin
         unique case (index)
            bzc_pkg::REG_SOURCE_WIDTH:  src_w_ff <= pwdata[8:0];
            bzc_pkg::REG_SOURCE_HEIGHT: src_h_ff <= pwdata[8:0];
            bzc_pkg::REG_STEP:          step_ff  <= pwdata[bzc_pkg::STEP_BITS-1:0];
            bzc_pkg::REG_SCALED_WIDTH:  scl_w_ff <= pwdata[bzc_pkg::SIZE_BITS-1:0];
            bzc_pkg::REG_SCALED_HEIGHT: scl_h_ff <= pwdata[bzc_pkg::SIZE_BITS-1:0];
            bzc_pkg::REG_EMIT_FULL:     full_ff  <= pwdata[0];
            default: ;
         endcase
      end
   end

   always_comb begin
      unique case (index)
         bzc_pkg::REG_SOURCE_WIDTH:  prdata = bzc_pkg::CSR_DATA_BITS'(src_w_ff);
         bzc_pkg::REG_SOURCE_HEIGHT: prdata = bzc_pkg::CSR_DATA_BITS'(src_h_ff);
         bzc_pkg::REG_STEP:          prdata = bzc_pkg::CSR_DATA_BITS'(step_ff);
         bzc_pkg::REG_SCALED_WIDTH:  prdata = bzc_pkg::CSR_DATA_BITS'(scl_w_ff);
         bzc_pkg::REG_SCALED_HEIGHT: prdata = bzc_pkg::CSR_DATA_BITS'(scl_h_ff);
         bzc_pkg::REG_EMIT_FULL:     prdata = bzc_pkg::CSR_DATA_BITS'(full_ff);
         default:                    prdata = '0;
      endcase
   end

   // Clamp sizes and work out the crop window once, off the item path.
   always_comb begin
      w_size  = clamp_size(bzc_pkg::SIZE_BITS'(src_w_ff),
                           bzc_pkg::SIZE_BITS'(bzc_pkg::MAX_WIDTH));
      h_size  = clamp_size(bzc_pkg::SIZE_BITS'(src_h_ff),
                           bzc_pkg::SIZE_BITS'(bzc_pkg::MAX_HEIGHT));
      sw_size = clamp_size(scl_w_ff, bzc_pkg::SIZE_BITS'(bzc_pkg::OUT_LIMIT));
      sh_size = clamp_size(scl_h_ff, bzc_pkg::SIZE_BITS'(bzc_pkg::OUT_LIMIT));
      diff_w  = sw_size - w_size;
      diff_h  = sh_size - h_size;

      cfg_in.width  = bzc_pkg::WIDTH_BITS'(w_size);
      cfg_in.height = bzc_pkg::HEIGHT_BITS'(h_size);
      area          = cfg_in.width * cfg_in.height;
      cfg_in.total  = bzc_pkg::TOTAL_BITS'(area);
      cfg_in.step   = step_ff;
      if (full_ff) begin
         cfg_in.out_width  = sw_size;
         cfg_in.out_height = sh_size;
         cfg_in.off_x      = '0;
         cfg_in.off_y      = '0;
      end else begin
         cfg_in.out_width  = w_size;
         cfg_in.out_height = h_size;
         cfg_in.off_x      = (sw_size > w_size) ?
                             bzc_pkg::COORD_BITS'(diff_w >> 1) : '0;
         cfg_in.off_y      = (sh_size > h_size) ?
                             bzc_pkg::COORD_BITS'(diff_h >> 1) : '0;
      end
   end

   always_ff @(posedge clock) begin
      cfg_ff <= cfg_in;
   end

   assign cfg = cfg_ff;

endmodule

>>> design/bzc_front.sv
module bzc_front (
   input  logic                            clock,
   input  logic                            reset,
   input  logic                            push,
   output logic                            full,
   input  logic                            opcode,
   input  logic [bzc_pkg::PIXEL_BITS-1:0]  pixel_in,
   output logic                            item_valid,
   output bzc_pkg::item_type               item,
   input  logic                            item_pop
);

   logic [bzc_pkg::QUEUE_CNT_BITS-1:0] count_ff;
   logic [bzc_pkg::QUEUE_CNT_BITS-1:0] count_in;
   logic [bzc_pkg::QUEUE_PTR_BITS-1:0] wr_ff;
   logic [bzc_pkg::QUEUE_PTR_BITS-1:0] wr_in;
   logic [bzc_pkg::QUEUE_PTR_BITS-1:0] rd_ff;
   logic [bzc_pkg::QUEUE_PTR_BITS-1:0] rd_in;
   bzc_pkg::item_type                  entry_ff [bzc_pkg::QUEUE_DEPTH];
   bzc_pkg::item_type                  entry_in;
   logic                               do_push;
   logic                               do_pop;

   assign full       = count_ff == bzc_pkg::QUEUE_CNT_BITS'(bzc_pkg::QUEUE_DEPTH);
   assign item_valid = count_ff != '0;
   assign do_push    = push & ~full;
   assign do_pop     = item_pop & item_valid;
   assign item       = entry_ff[rd_ff];

   // Tag the request as a pixel load or an output request.
   always_comb begin
      entry_in.opcode = (opcode == 1'b1) ? bzc_pkg::OP_EMIT : bzc_pkg::OP_LOAD;
      entry_in.pixel  = pixel_in;
      count_in = count_ff + bzc_pkg::QUEUE_CNT_BITS'(do_push)
                          - bzc_pkg::QUEUE_CNT_BITS'(do_pop);
      wr_in    = do_push ? bzc_pkg::queue_next(wr_ff) : wr_ff;
      rd_in    = do_pop ? bzc_pkg::queue_next(rd_ff) : rd_ff;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff <= '0;
         wr_ff    <= '0;
         rd_ff    <= '0;
      end else begin
         count_ff <= count_in;
         wr_ff    <= wr_in;
         rd_ff    <= rd_in;
      end
   end

   always_ff @(posedge clock) begin
      if (do_push) begin
         entry_ff[wr_ff] <= entry_in;
      end
   end

endmodule

>>> design/bzc_back.sv
module bzc_back (
   input  logic                 clock,
   input  logic                 reset,
   input  bzc_pkg::cfg_type     cfg,
   input  logic                 item_valid,
   input  bzc_pkg::item_type    item,
   output logic                 item_pop,
   input  logic                 res_space,
   output logic                 res_push,
   output bzc_pkg::result_type  res
);

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_SCALE,
      ST_BASE,
      ST_FETCH,
      ST_DRAIN,
      ST_MIX_H,
      ST_MIX_V
   } state_type;

   typedef struct packed {
      logic [bzc_pkg::SIZE_BITS-1:0] lo;
      logic                          inc;
      logic [bzc_pkg::FRAC_BITS-1:0] frac;
   } loc_type;

   state_type                           state_ff;
   state_type                           state_in;
   logic [1:0]                          fetch_ff;
   logic [1:0]                          fetch_in;
   logic [bzc_pkg::COORD_BITS-1:0]      col_ff;
   logic [bzc_pkg::COORD_BITS-1:0]      col_in;
   logic [bzc_pkg::COORD_BITS-1:0]      row_ff;
   logic [bzc_pkg::COORD_BITS-1:0]      row_in;
   logic [bzc_pkg::TOTAL_BITS-1:0]      ptr_ff;
   logic [bzc_pkg::TOTAL_BITS-1:0]      ptr_in;
   logic                                rvalid_ff;

   logic [bzc_pkg::SIZE_BITS-1:0]       cx_ff;
   logic [bzc_pkg::SIZE_BITS-1:0]       cy_ff;
   logic [bzc_pkg::PROD_BITS-1:0]       sx_ff;
   logic [bzc_pkg::PROD_BITS-1:0]       sy_ff;
   logic [bzc_pkg::COL_BITS-1:0]        x_lo_ff;
   logic                                x_inc_ff;
   logic [bzc_pkg::FRAC_BITS-1:0]       u_ff;
   logic [bzc_pkg::FRAC_BITS-1:0]       v_ff;
   logic [bzc_pkg::ADDR_BITS-1:0]       base0_ff;
   logic [bzc_pkg::ADDR_BITS-1:0]       base1_ff;
   logic [bzc_pkg::PIXEL_BITS-1:0]      samp_ff [4];
   logic [bzc_pkg::MIX_BITS-1:0]        top_ff;
   logic [bzc_pkg::MIX_BITS-1:0]        bot_ff;
   logic [bzc_pkg::COORD_BITS-1:0]      x_ff;
   logic [bzc_pkg::COORD_BITS-1:0]      y_ff;
   logic                                last_ff;

   logic                                take;
   logic                                is_emit;
   logic                                last_col;
   logic                                last_row;
   logic [bzc_pkg::TOTAL_BITS-1:0]      load_ptr;
   logic [bzc_pkg::TOTAL_BITS-1:0]      load_next;
   loc_type                             loc_x;
   loc_type                             loc_y;
   logic [bzc_pkg::ROW_BITS-1:0]        y_lo;
   logic [bzc_pkg::ROW_BITS-1:0]        y_hi;
   logic [bzc_pkg::ROW_BITS+bzc_pkg::WIDTH_BITS-1:0] base0_full;
   logic [bzc_pkg::ROW_BITS+bzc_pkg::WIDTH_BITS-1:0] base1_full;
   logic [bzc_pkg::ADDR_BITS-1:0]       row_base;
   logic                                rd_en;
   logic [bzc_pkg::ADDR_BITS-1:0]       rd_addr;
   logic [bzc_pkg::PIXEL_BITS-1:0]      rd_data;
   logic signed [bzc_pkg::PIXEL_BITS:0]        d_top;
   logic signed [bzc_pkg::PIXEL_BITS:0]        d_bot;
   logic signed [bzc_pkg::MIX_BITS+1:0]        p_top;
   logic signed [bzc_pkg::MIX_BITS+1:0]        p_bot;
   logic signed [bzc_pkg::MIX_BITS+1:0]        s_top;
   logic signed [bzc_pkg::MIX_BITS+1:0]        s_bot;
   logic signed [bzc_pkg::MIX_BITS:0]          d_ver;
   logic signed [bzc_pkg::MIX_BITS+bzc_pkg::FRAC_BITS+1:0] p_ver;
   logic signed [bzc_pkg::MIX_BITS+bzc_pkg::FRAC_BITS+1:0] s_ver;

   // Split a scaled coordinate into left sample, step to the right one, weight.
   function automatic loc_type locate(
      input logic [bzc_pkg::PROD_BITS-1:0] s,
      input logic [bzc_pkg::SIZE_BITS-1:0] size
   );
      loc_type                       r;
      logic [bzc_pkg::INT_BITS-1:0]  i;
      logic [bzc_pkg::SIZE_BITS-1:0] edge_pos;
      i        = s[bzc_pkg::PROD_BITS-1:bzc_pkg::FRAC_BITS];
      edge_pos = size - 1'b1;
      if (i >= bzc_pkg::INT_BITS'(edge_pos)) begin
         r.lo   = edge_pos;
         r.inc  = 1'b0;
         r.frac = '0;
      end else begin
         r.lo   = bzc_pkg::SIZE_BITS'(i);
         r.inc  = 1'b1;
         r.frac = s[bzc_pkg::FRAC_BITS-1:0];
      end
      return r;
   endfunction

   assign is_emit  = item.opcode == bzc_pkg::OP_EMIT;
   assign take     = (state_ff == ST_IDLE) && item_valid;
   assign item_pop = take;
   assign last_col = {1'b0, col_ff} >= (cfg.out_width - 1'b1);
   assign last_row = {1'b0, row_ff} >= (cfg.out_height - 1'b1);
   assign load_ptr  = (ptr_ff >= cfg.total) ? '0 : ptr_ff;
   assign load_next = load_ptr + 1'b1;

   always_comb begin
      state_in = state_ff;
      fetch_in = fetch_ff;
      col_in   = col_ff;
      row_in   = row_ff;
      ptr_in   = ptr_ff;
      unique case (state_ff)
         ST_IDLE: begin
            if (take && !is_emit) begin
               ptr_in = (load_next >= cfg.total) ? '0 : load_next;
            end
            if (take && is_emit) begin
               state_in = ST_SCALE;
               if (last_col) begin
                  col_in = '0;
                  row_in = last_row ? '0 : row_ff + 1'b1;
               end else begin
                  col_in = col_ff + 1'b1;
               end
            end
         end
         ST_SCALE: state_in = ST_BASE;
         ST_BASE: begin
            state_in = ST_FETCH;
            fetch_in = '0;
         end
         ST_FETCH: begin
            fetch_in = fetch_ff + 1'b1;
            if (&fetch_ff) begin
               state_in = ST_DRAIN;
            end
         end
         ST_DRAIN: state_in = ST_MIX_H;
         ST_MIX_H: state_in = ST_MIX_V;
         ST_MIX_V: begin
            if (res_space) begin
               state_in = ST_IDLE;
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff  <= ST_IDLE;
         fetch_ff  <= '0;
         col_ff    <= '0;
         row_ff    <= '0;
         ptr_ff    <= '0;
         rvalid_ff <= 1'b0;
      end else begin
         state_ff  <= state_in;
         fetch_ff  <= fetch_in;
         col_ff    <= col_in;
         row_ff    <= row_in;
         ptr_ff    <= ptr_in;
         rvalid_ff <= rd_en;
      end
   end

   always_comb begin
      loc_x      = locate(sx_ff, bzc_pkg::SIZE_BITS'(cfg.width));
      loc_y      = locate(sy_ff, bzc_pkg::SIZE_BITS'(cfg.height));
      y_lo       = bzc_pkg::ROW_BITS'(loc_y.lo);
      y_hi       = y_lo + bzc_pkg::ROW_BITS'(loc_y.inc);
      base0_full = y_lo * cfg.width;
      base1_full = y_hi * cfg.width;
   end

   // Four reads: top-left, top-right, bottom-left, bottom-right.
   assign rd_en    = state_ff == ST_FETCH;
   assign row_base = fetch_ff[1] ? base1_ff : base0_ff;
   assign rd_addr  = row_base + bzc_pkg::ADDR_BITS'(x_lo_ff)
                     + bzc_pkg::ADDR_BITS'(fetch_ff[0] & x_inc_ff);

   always_comb begin
      d_top = $signed({1'b0, samp_ff[2]}) - $signed({1'b0, samp_ff[3]});
      d_bot = $signed({1'b0, samp_ff[0]}) - $signed({1'b0, samp_ff[1]});
      p_top = d_top * $signed({1'b0, u_ff});
      p_bot = d_bot * $signed({1'b0, u_ff});
      s_top = $signed({2'b00, samp_ff[3], {bzc_pkg::FRAC_BITS{1'b0}}}) + p_top;
      s_bot = $signed({2'b00, samp_ff[1], {bzc_pkg::FRAC_BITS{1'b0}}}) + p_bot;
      d_ver = $signed({1'b0, bot_ff}) - $signed({1'b0, top_ff});
      p_ver = d_ver * $signed({1'b0, v_ff});
      s_ver = $signed({2'b00, top_ff, {bzc_pkg::FRAC_BITS{1'b0}}}) + p_ver;
   end

   always_ff @(posedge clock) begin
      if (take && is_emit) begin
         cx_ff   <= bzc_pkg::SIZE_BITS'(col_ff) + bzc_pkg::SIZE_BITS'(cfg.off_x);
         cy_ff   <= bzc_pkg::SIZE_BITS'(row_ff) + bzc_pkg::SIZE_BITS'(cfg.off_y);
         x_ff    <= col_ff;
         y_ff    <= row_ff;
         last_ff <= last_col && last_row;
      end
      if (state_ff == ST_SCALE) begin
         sx_ff <= cx_ff * cfg.step;
         sy_ff <= cy_ff * cfg.step;
      end
      if (state_ff == ST_BASE) begin
         x_lo_ff  <= bzc_pkg::COL_BITS'(loc_x.lo);
         x_inc_ff <= loc_x.inc;
         u_ff     <= loc_x.frac;
         v_ff     <= loc_y.frac;
         base0_ff <= bzc_pkg::ADDR_BITS'(base0_full);
         base1_ff <= bzc_pkg::ADDR_BITS'(base1_full);
      end
      if (rvalid_ff) begin
         samp_ff[0] <= rd_data;
         samp_ff[1] <= samp_ff[0];
         samp_ff[2] <= samp_ff[1];
         samp_ff[3] <= samp_ff[2];
      end
      if (state_ff == ST_MIX_H) begin
         top_ff <= s_top[bzc_pkg::MIX_BITS-1:0];
         bot_ff <= s_bot[bzc_pkg::MIX_BITS-1:0];
      end
   end

   bzc_ram #(
      .WIDTH (bzc_pkg::PIXEL_BITS),
      .DEPTH (bzc_pkg::STORE_DEPTH)
   ) u_store (
      .clock   (clock),
      .wr_en   (take && !is_emit),
      .wr_addr (bzc_pkg::ADDR_BITS'(load_ptr)),
      .wr_data (item.pixel),
      .rd_en   (rd_en),
      .rd_addr (rd_addr),
      .rd_data (rd_data)
   );

   assign res_push  = (state_ff == ST_MIX_V) && res_space;
   assign res.pixel = s_ver[bzc_pkg::MIX_BITS+bzc_pkg::FRAC_BITS-1:bzc_pkg::MIX_BITS];
   assign res.x     = x_ff;
   assign res.y     = y_ff;
   assign res.last  = last_ff;

endmodule

>>> design/bzc_rspq.sv
module bzc_rspq (
   input  logic                            clock,
   input  logic                            reset,
   input  logic                            res_push,
   input  bzc_pkg::result_type             res,
   output logic                            res_space,
   output logic                            empty,
   input  logic                            pop,
   output logic [bzc_pkg::PIXEL_BITS-1:0]  pixel_out,
   output logic [bzc_pkg::COORD_BITS-1:0]  out_x,
   output logic [bzc_pkg::COORD_BITS-1:0]  out_y,
   output logic                            frame_last
);

   logic [bzc_pkg::QUEUE_CNT_BITS-1:0] count_ff;
   logic [bzc_pkg::QUEUE_CNT_BITS-1:0] count_in;
   logic [bzc_pkg::QUEUE_PTR_BITS-1:0] wr_ff;
   logic [bzc_pkg::QUEUE_PTR_BITS-1:0] wr_in;
   logic [bzc_pkg::QUEUE_PTR_BITS-1:0] rd_ff;
   logic [bzc_pkg::QUEUE_PTR_BITS-1:0] rd_in;
   bzc_pkg::result_type                entry_ff [bzc_pkg::QUEUE_DEPTH];
   bzc_pkg::result_type                head;
   logic                               do_push;
   logic                               do_pop;

   assign res_space = count_ff != bzc_pkg::QUEUE_CNT_BITS'(bzc_pkg::QUEUE_DEPTH);
   assign empty     = count_ff == '0;
   assign do_push   = res_push & res_space;
   assign do_pop    = pop & ~empty;
   assign head      = entry_ff[rd_ff];

   assign pixel_out  = head.pixel;
   assign out_x      = head.x;
   assign out_y      = head.y;
   assign frame_last = head.last;

   always_comb begin
      count_in = count_ff + bzc_pkg::QUEUE_CNT_BITS'(do_push)
                          - bzc_pkg::QUEUE_CNT_BITS'(do_pop);
      wr_in    = do_push ? bzc_pkg::queue_next(wr_ff) : wr_ff;
      rd_in    = do_pop ? bzc_pkg::queue_next(rd_ff) : rd_ff;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff <= '0;
         wr_ff    <= '0;
         rd_ff    <= '0;
      end else begin
         count_ff <= count_in;
         wr_ff    <= wr_in;
         rd_ff    <= rd_in;
      end
   end

   always_ff @(posedge clock) begin
      if (do_push) begin
         entry_ff[wr_ff] <= res;
      end
   end

endmodule

>>> design/bilinear_zoom_center_crop.sv
// Load request: held in the request queue, then written to the frame memory when taken;
// one per cycle while no output request is in progress. Output request: scale, address,
// four reads on the single frame memory read port, drain and two blend steps; no new
// request is taken until the result has been pushed to the result queue.
// Reset clears the queues, load pointer, output position and registers to defaults;
// frame memory contents are kept.
module bilinear_zoom_center_crop (
   input  logic                               clock,
   input  logic                               reset,
   input  logic                               push,
   output logic                               full,
   input  logic                               req_opcode,
   input  logic [bzc_pkg::PIXEL_BITS-1:0]     req_pixel_in,
   output logic                               empty,
   input  logic                               pop,
   output logic [bzc_pkg::PIXEL_BITS-1:0]     rsp_pixel_out,
   output logic [bzc_pkg::COORD_BITS-1:0]     rsp_out_x,
   output logic [bzc_pkg::COORD_BITS-1:0]     rsp_out_y,
   output logic                               rsp_frame_last,
   input  logic                               psel,
   input  logic                               penable,
   input  logic                               pwrite,
   input  logic [bzc_pkg::CSR_ADDR_BITS-1:0]  paddr,
   input  logic [bzc_pkg::CSR_DATA_BITS-1:0]  pwdata,
   output logic [bzc_pkg::CSR_DATA_BITS-1:0]  prdata,
   output logic                               pready
);

   bzc_pkg::cfg_type     cfg;
   bzc_pkg::item_type    item;
   bzc_pkg::result_type  res;
   logic                 item_valid;
   logic                 item_pop;
   logic                 res_push;
   logic                 res_space;

   assign pready = 1'b1;

   bzc_csr u_csr (
      .clock   (clock),
      .reset   (reset),
      .psel    (psel),
      .penable (penable),
      .pwrite  (pwrite),
      .paddr   (paddr),
      .pwdata  (pwdata),
      .prdata  (prdata),
      .cfg     (cfg)
   );

   bzc_front u_front (
      .clock      (clock),
      .reset      (reset),
      .push       (push),
      .full       (full),
      .opcode     (req_opcode),
      .pixel_in   (req_pixel_in),
      .item_valid (item_valid),
      .item       (item),
      .item_pop   (item_pop)
   );

   bzc_back u_back (
      .clock      (clock),
      .reset      (reset),
      .cfg        (cfg),
      .item_valid (item_valid),
      .item       (item),
      .item_pop   (item_pop),
      .res_space  (res_space),
      .res_push   (res_push),
      .res        (res)
   );

   bzc_rspq u_rspq (
      .clock      (clock),
      .reset      (reset),
      .res_push   (res_push),
      .res        (res),
      .res_space  (res_space),
      .empty      (empty),
      .pop        (pop),
      .pixel_out  (rsp_pixel_out),
      .out_x      (rsp_out_x),
      .out_y      (rsp_out_y),
      .frame_last (rsp_frame_last)
   );

   a_request_queued: assert property (@(posedge clock) disable iff (reset)
      (push && !full) |=> item_valid)
      else $error("accepted request not visible to the back end");

   a_result_queued: assert property (@(posedge clock) disable iff (reset)
      res_push |=> !empty)
      else $error("result pushed but result queue empty");

   a_no_push_after_take: assert property (@(posedge clock) disable iff (reset)
      item_pop |=> !res_push)
      else $error("result pushed right after a request was taken");

endmodule

>>> test/tb_top.sv
module tb_top;
   import bzc_pkg::*;

   localparam int CYCLE_LIMIT = 400000;
   localparam int SETTLE_CYCLES = 16;
   localparam int RANDOM_ITEMS = 1250;

   logic                       clock;
   logic                       reset;
   logic                       push;
   logic                       full;
   logic                       req_opcode;
   logic [PIXEL_BITS-1:0]      req_pixel_in;
   logic                       empty;
   logic                       pop;
   logic [PIXEL_BITS-1:0]      rsp_pixel_out;
   logic [COORD_BITS-1:0]      rsp_out_x;
   logic [COORD_BITS-1:0]      rsp_out_y;
   logic                       rsp_frame_last;
   logic                       psel;
   logic                       penable;
   logic                       pwrite;
   logic [CSR_ADDR_BITS-1:0]   paddr;
   logic [CSR_DATA_BITS-1:0]   pwdata;
   logic [CSR_DATA_BITS-1:0]   prdata;
   logic                       pready;

   // zoom state mirrored for prediction
   logic [PIXEL_BITS-1:0]      frame_mem [0:STORE_DEPTH-1];
   int unsigned                load_ptr;
   logic [COORD_BITS-1:0]      col_pos;
   logic [COORD_BITS-1:0]      row_pos;
   logic [8:0]                 cfg_source_w;
   logic [8:0]                 cfg_source_h;
   logic [STEP_BITS-1:0]       cfg_step;
   logic [SIZE_BITS-1:0]       cfg_scaled_w;
   logic [SIZE_BITS-1:0]       cfg_scaled_h;
   logic                       cfg_full;

   result_type                 pending_pixels [$];
   int unsigned                errors;
   int unsigned                loads_sent;
   int unsigned                emits_sent;
   int unsigned                pixels_checked;
   int unsigned                frames_done;
   int unsigned                settings_used;
   int unsigned                cycle_count;
   int unsigned                stall_left;
   bit                         bursts_on;

   bilinear_zoom_center_crop i_dut (
      .clock          (clock),
      .reset          (reset),
      .push           (push),
      .full           (full),
      .req_opcode     (req_opcode),
      .req_pixel_in   (req_pixel_in),
      .empty          (empty),
      .pop            (pop),
      .rsp_pixel_out  (rsp_pixel_out),
      .rsp_out_x      (rsp_out_x),
      .rsp_out_y      (rsp_out_y),
      .rsp_frame_last (rsp_frame_last),
      .psel           (psel),
      .penable        (penable),
      .pwrite         (pwrite),
      .paddr          (paddr),
      .pwdata         (pwdata),
      .prdata         (prdata),
      .pready         (pready)
   );

   always begin
      clock = 1'b0;
      #6;
      clock = 1'b1;
      #6;
   end

   function automatic int unsigned clamp_size(int unsigned v, int unsigned hi);
      if (v < 1) return 1;
      if (v > hi) return hi;
      return v;
   endfunction

   function automatic int unsigned read_pixel(int unsigned x, int unsigned y, int unsigned w);
      int unsigned a;
      a = y * w + x;
      return (a < STORE_DEPTH) ? int'(frame_mem[a]) : 0;
   endfunction

   // split a scaled coordinate into left sample, right sample and Q16 weight
   function automatic void split_coord(input int unsigned coord, input int unsigned size,
                                       output int unsigned lo, output int unsigned hi,
                                       output int unsigned frac);
      longint unsigned s;
      s = longint'(coord) * longint'(cfg_step);
      if ((s >> 16) >= longint'(size - 1)) begin
         lo = size - 1;
         hi = size - 1;
         frac = 0;
      end else begin
         lo = int'(s >> 16);
         hi = lo + 1;
         frac = int'(s & 64'hFFFF);
      end
   endfunction

   function automatic void predict_item(opcode_type op, logic [PIXEL_BITS-1:0] pix);
      int unsigned w, h, sw, sh, total, p, ow, oh, offx, offy;
      int unsigned x0, x1, u, y0, y1, v;
      longint unsigned top, bot, val;
      bit last_col, last_row;
      result_type r;
      w = clamp_size(cfg_source_w, MAX_WIDTH);
      h = clamp_size(cfg_source_h, MAX_HEIGHT);
      sw = clamp_size(cfg_scaled_w, OUT_LIMIT);
      sh = clamp_size(cfg_scaled_h, OUT_LIMIT);
      if (op == OP_LOAD) begin
         total = w * h;
         p = (load_ptr >= total) ? 0 : load_ptr;
         frame_mem[p] = pix;
         p = p + 1;
         load_ptr = (p >= total) ? 0 : p;
         return;
      end
      offx = 0;
      offy = 0;
      if (cfg_full) begin
         ow = sw;
         oh = sh;
      end else begin
         ow = w;
         oh = h;
         if (sw > w) offx = (sw - w) / 2;
         if (sh > h) offy = (sh - h) / 2;
      end
      split_coord(int'(col_pos) + offx, w, x0, x1, u);
      split_coord(int'(row_pos) + offy, h, y0, y1, v);
      top = longint'(read_pixel(x0, y0, w)) * (65536 - u) +
            longint'(read_pixel(x1, y0, w)) * u;
      bot = longint'(read_pixel(x0, y1, w)) * (65536 - u) +
            longint'(read_pixel(x1, y1, w)) * u;
      val = (top * (65536 - v) + bot * v) >> 32;
      last_col = int'(col_pos) >= ow - 1;
      last_row = int'(row_pos) >= oh - 1;
      r.pixel = val[PIXEL_BITS-1:0];
      r.x = col_pos;
      r.y = row_pos;
      r.last = last_col && last_row;
      pending_pixels.push_back(r);
      if (last_col) begin
         col_pos = '0;
         row_pos = last_row ? '0 : row_pos + 1'b1;
      end else begin
         col_pos = col_pos + 1'b1;
      end
   endfunction

   function automatic logic [PIXEL_BITS-1:0] next_pixel();
      if ($urandom_range(0, 7) == 0) return $urandom_range(0, 1) ? 16'hFFFF : 16'h0000;
      return PIXEL_BITS'($urandom);
   endfunction

   function automatic int unsigned scaled_size(int unsigned n, int unsigned step);
      longint unsigned s;
      s = (longint'(n) * 65536 + step / 2) / step;
      return (s > 8191) ? 8191 : int'(s);
   endfunction

   task automatic send_item(opcode_type op, logic [PIXEL_BITS-1:0] pix);
      if (bursts_on && $urandom_range(0, 9) == 0) begin
         push <= 1'b0;
         repeat ($urandom_range(1, 12)) @(posedge clock);
      end
      push <= 1'b1;
      req_opcode <= op;
      req_pixel_in <= pix;
      do @(posedge clock); while (full);
      predict_item(op, pix);
      if (op == OP_LOAD) loads_sent++;
      else emits_sent++;
   endtask

   // drain all results, then let trailing loads land
   task automatic wait_idle();
      push <= 1'b0;
      while (pending_pixels.size() != 0) @(posedge clock);
      repeat (SETTLE_CYCLES) @(posedge clock);
   endtask

   task automatic write_csr(reg_index_type idx, logic [31:0] val);
      psel <= 1'b1;
      penable <= 1'b0;
      pwrite <= 1'b1;
      paddr <= CSR_ADDR_BITS'(4 * idx);
      pwdata <= val;
      @(posedge clock);
      penable <= 1'b1;
      do @(posedge clock); while (!pready);
      case (idx)
         REG_SOURCE_WIDTH:  cfg_source_w = val[8:0];
         REG_SOURCE_HEIGHT: cfg_source_h = val[8:0];
         REG_STEP:          cfg_step = val[STEP_BITS-1:0];
         REG_SCALED_WIDTH:  cfg_scaled_w = val[SIZE_BITS-1:0];
         REG_SCALED_HEIGHT: cfg_scaled_h = val[SIZE_BITS-1:0];
         REG_EMIT_FULL:     cfg_full = val[0];
         default: ;
      endcase
   endtask

   task automatic configure(int unsigned w, int unsigned h, int unsigned step,
                            int unsigned sw, int unsigned sh, int unsigned full_frame);
      wait_idle();
      write_csr(REG_SOURCE_WIDTH, w);
      write_csr(REG_SOURCE_HEIGHT, h);
      write_csr(REG_STEP, step);
      write_csr(REG_SCALED_WIDTH, sw);
      write_csr(REG_SCALED_HEIGHT, sh);
      write_csr(REG_EMIT_FULL, full_frame);
      psel <= 1'b0;
      penable <= 1'b0;
      pwrite <= 1'b0;
      settings_used++;
   endtask

   task automatic run_zoom_phase(int unsigned w, int unsigned h, int unsigned step,
                                 int unsigned sw, int unsigned sh, int unsigned full_frame,
                                 int unsigned n_emit);
      int unsigned frame;
      configure(w, h, step, sw, sh, full_frame);
      frame = clamp_size(w, MAX_WIDTH) * clamp_size(h, MAX_HEIGHT);
      repeat (frame) send_item(OP_LOAD, next_pixel());
      repeat (n_emit) begin
         if ($urandom_range(0, 5) == 0) send_item(OP_LOAD, next_pixel());
         send_item(OP_EMIT, PIXEL_BITS'($urandom));
      end
   endtask

   // 2x zoom of a 3x2 frame, centered crop with nonzero offsets
   task automatic test_crop_window();
      configure(3, 2, 32768, 6, 4, 0);
      send_item(OP_LOAD, 16'h0000);
      send_item(OP_LOAD, 16'hFFFF);
      send_item(OP_LOAD, 16'h1234);
      send_item(OP_LOAD, 16'hFFFF);
      send_item(OP_LOAD, 16'h0000);
      send_item(OP_LOAD, 16'h8001);
      repeat (6) send_item(OP_EMIT, 16'h0000);
   endtask

   // stop mid-row in full mode, then shrink to a crop smaller than the source
   task automatic test_position_carry();
      configure(3, 2, 32768, 5, 2, 1);
      repeat (3) send_item(OP_EMIT, 16'hFFFF);
      configure(3, 2, 32768, 2, 1, 0);
      repeat (3) send_item(OP_EMIT, 16'h5A5A);
   endtask

   // leave the load pointer past a shrunken frame, then zero step
   task automatic test_load_wrap();
      configure(5, 2, 65536, 5, 2, 0);
      repeat (7) send_item(OP_LOAD, next_pixel());
      configure(2, 2, 0, 2, 2, 0);
      repeat (4) send_item(OP_LOAD, next_pixel());
      repeat (2) send_item(OP_EMIT, 16'hA5A5);
   endtask

   task automatic test_random_zoom(int unsigned item_goal);
      int unsigned start, done, phase, w, h, step, sw, sh, full_frame, n_emit;
      start = loads_sent + emits_sent;
      phase = 0;
      done = 0;
      while (done < item_goal) begin
         // quiet tail: no idling on either side
         bursts_on = (done < item_goal * 9 / 10) && ($urandom_range(0, 3) != 0);
         w = $urandom_range(1, ($urandom_range(0, 3) == 0) ? 16 : 6);
         h = $urandom_range(1, ($urandom_range(0, 3) == 0) ? 16 : 6);
         step = $urandom_range(4096, 65536);
         sw = scaled_size(w, step);
         sh = scaled_size(h, step);
         if ($urandom_range(0, 4) == 0) begin
            sw = $urandom_range(0, 20);
            sh = $urandom_range(0, 20);
         end
         full_frame = $urandom_range(0, 1);
         if (phase % 2 == 1) begin
            case (phase / 2)
               0: begin
                  w = 511;
                  h = 0;
                  sw = scaled_size(MAX_WIDTH, step);
                  sh = 1;
                  full_frame = 0;
               end
               1: begin
                  w = 0;
                  h = 511;
                  sw = 1;
                  sh = scaled_size(MAX_HEIGHT, step);
                  full_frame = 0;
               end
               2: step = 0;
               3: begin
                  step = 131071;
                  sw = scaled_size(w, step);
                  sh = scaled_size(h, step);
               end
               4: begin
                  full_frame = 1;
                  sw = 8191;
                  sh = 0;
               end
               5: begin
                  full_frame = 1;
                  sw = 0;
                  sh = 8191;
               end
               default: ;
            endcase
         end
         if (full_frame) begin
            n_emit = $urandom_range(10, 60);
         end else begin
            n_emit = clamp_size(w, MAX_WIDTH) * clamp_size(h, MAX_HEIGHT) *
                     $urandom_range(1, 2);
            if (n_emit > 64) n_emit = 64;
         end
         run_zoom_phase(w, h, step, sw, sh, full_frame, n_emit);
         phase++;
         done = loads_sent + emits_sent - start;
      end
      bursts_on = 0;
   endtask

   task automatic compare_field(string name, int unsigned want, int unsigned got);
      if (want != got) begin
         errors++;
         $display("%0t: %s expected %0d actual %0d", $time, name, want, got);
      end
   endtask

   always @(posedge clock) begin : check_output
      result_type want;
      if (!reset && pop && !empty) begin
         if (pending_pixels.size() == 0) begin
            errors++;
            $display("%0t: output pixel expected none actual x %0d y %0d value %0d",
                     $time, rsp_out_x, rsp_out_y, rsp_pixel_out);
         end else begin
            want = pending_pixels.pop_front();
            compare_field("pixel_out", want.pixel, rsp_pixel_out);
            compare_field("out_x", want.x, rsp_out_x);
            compare_field("out_y", want.y, rsp_out_y);
            compare_field("frame_last", want.last, rsp_frame_last);
            pixels_checked++;
            if (want.last) frames_done++;
         end
      end
   end

   // result side stalls in bursts
   always @(posedge clock) begin
      if (reset) begin
         pop <= 1'b0;
         stall_left = 0;
      end else if (stall_left != 0) begin
         stall_left--;
         pop <= 1'b0;
      end else if (bursts_on && $urandom_range(0, 9) == 0) begin
         stall_left = $urandom_range(0, 11);
         pop <= 1'b0;
      end else begin
         pop <= 1'b1;
      end
   end

   initial begin : watchdog
      cycle_count = 0;
      while (cycle_count < CYCLE_LIMIT) begin
         @(posedge clock);
         cycle_count++;
      end
      $display("Timed out after %0d cycles", cycle_count);
      $display("Mismatches found");
      $finish;
   end

   initial begin
      reset <= 1'b1;
      push <= 1'b0;
      req_opcode <= OP_LOAD;
      req_pixel_in <= '0;
      psel <= 1'b0;
      penable <= 1'b0;
      pwrite <= 1'b0;
      paddr <= '0;
      pwdata <= '0;
      load_ptr = 0;
      col_pos = '0;
      row_pos = '0;
      cfg_source_w = 9'd256;
      cfg_source_h = 9'd256;
      cfg_step = 17'd65536;
      cfg_scaled_w = 13'd256;
      cfg_scaled_h = 13'd256;
      cfg_full = 1'b0;
      errors = 0;
      loads_sent = 0;
      emits_sent = 0;
      pixels_checked = 0;
      frames_done = 0;
      settings_used = 0;
      bursts_on = 1;
      foreach (frame_mem[i]) frame_mem[i] = '0;
      repeat (3) @(posedge clock);
      reset <= 1'b0;

      test_crop_window();
      test_position_carry();
      test_load_wrap();
      test_random_zoom(RANDOM_ITEMS);
      wait_idle();

      $display("Sent %0d load and %0d emit requests across %0d register settings",
               loads_sent, emits_sent, settings_used);
      $display("Checked %0d output pixels, %0d of them closing a frame",
               pixels_checked, frames_done);
      if (errors == 0) begin
         $display("No mismatches found");
      end else begin
         $display("Mismatches found");
      end
      $finish;
   end

endmodule
